### rtl/core/mmr_pkg.sv
`timescale 1ns / 1ps
// mmr_pkg: shared types and codes of the modulation matrix router
// no dependencies; used by mmr_cell, modulation_matrix_router and tb_modulation_matrix_router
package mmr_pkg;

    typedef struct packed {
        logic               valid;
        logic [4:0]         source;
        logic [4:0]         dest;
        logic signed [16:0] amount;
        logic [15:0]        id;
    } entry_t;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_CLEAR  = 3'd2;
    localparam logic [2:0] KIND_SET    = 3'd3;
    localparam logic [2:0] KIND_GET    = 3'd4;
    localparam logic [2:0] KIND_QUERY  = 3'd5;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;
    localparam logic [1:0] STATUS_BAD_SOURCE = 2'd3;

    localparam logic signed [16:0] AMOUNT_MAX = 17'sd32768;
    localparam logic signed [16:0] AMOUNT_MIN = -17'sd32768;

endpackage

### rtl/core/modulation_matrix_router.sv
`timescale 1ns / 1ps
// modulation_matrix_router: routing table as a rotating chain of slot cells plus source bank
// depends on mmr_pkg, mmr_cell and mmr_mac
//
// Set, get, unused codes and adds to a bad source put their result out in the cycle after
// the input transfer, so they can follow each other with no gap. Add, remove, clear and
// query rotate the whole routing chain once past a single head stage, one slot per cycle,
// then pass through the drain and done states before the result transfer; the query sum
// goes through one multiplier and accumulator at the head. One item is in work at a time;
// while a result waits under out_stall the input stalls too.
module modulation_matrix_router
    import mmr_pkg::*;
#(
    parameter int MAX_ROUTINGS = 32,
    parameter int NUM_SOURCES  = 16,
    parameter int NUM_DESTS    = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [4:0]         source_index,
    input  logic [4:0]         dest_index,
    input  logic signed [16:0] amount,
    input  logic [15:0]        routing_id,
    input  logic signed [15:0] source_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [15:0]        new_id,
    output logic signed [36:0] value
);

    localparam int CNT_W = (MAX_ROUTINGS > 1) ? $clog2(MAX_ROUTINGS) : 1;
    localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ROUTINGS - 1);
    localparam logic [5:0] SRC_LIMIT = 6'(NUM_SOURCES);
    localparam logic [5:0] DST_LIMIT = 6'(NUM_DESTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [2:0]         kind_reg;
    logic [4:0]         src_reg;
    logic [4:0]         dst_reg;
    logic               dst_ok_reg;
    logic signed [16:0] amt_reg;
    logic [15:0]        rid_reg;
    logic               found_reg;
    logic               hit_reg;
    logic [15:0]        id_counter_reg;
    logic signed [15:0] level_reg [NUM_SOURCES];

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [15:0]        new_id_reg;
    logic signed [36:0] value_reg;

    entry_t             chain [MAX_ROUTINGS];
    entry_t             head;
    entry_t             feed;
    logic               sweeping;
    logic               accept;
    logic               src_ok;
    logic               out_free;
    logic               immediate;
    logic               take_slot;
    logic               drop_slot;
    logic               mac_en;
    logic signed [15:0] head_level;
    logic signed [15:0] get_level;
    logic signed [16:0] amt_clamped;
    logic signed [36:0] acc;

    assign sweeping  = (state_reg == S_SWEEP);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign src_ok    = ({1'b0, source_index} < SRC_LIMIT);
    assign immediate = !(kind == KIND_REMOVE || kind == KIND_CLEAR || kind == KIND_QUERY
                         || (kind == KIND_ADD && src_ok));
    assign head      = chain[MAX_ROUTINGS-1];
    assign get_level = src_ok ? level_reg[source_index[SRC_W-1:0]] : 16'sd0;

    always_comb
    begin
        if (amount > AMOUNT_MAX)
        begin
            amt_clamped = AMOUNT_MAX;
        end
        else if (amount < AMOUNT_MIN)
        begin
            amt_clamped = AMOUNT_MIN;
        end
        else
        begin
            amt_clamped = amount;
        end
    end

    // head stage: edit the slot as it passes back into the tail of the chain
    always_comb
    begin
        take_slot = (kind_reg == KIND_ADD) && !head.valid && !found_reg;
        drop_slot = ((kind_reg == KIND_REMOVE) && head.valid && (head.id == rid_reg))
                    || (kind_reg == KIND_CLEAR);
        feed = head;
        if (take_slot)
        begin
            feed.valid  = 1'b1;
            feed.source = src_reg;
            feed.dest   = dst_reg;
            feed.amount = amt_reg;
            feed.id     = id_counter_reg;
        end
        else if (drop_slot)
        begin
            feed.valid = 1'b0;
        end
    end

    assign mac_en = sweeping && (kind_reg == KIND_QUERY) && dst_ok_reg && head.valid
                    && (head.dest == dst_reg);
    assign head_level = ({1'b0, head.source} < SRC_LIMIT)
                        ? level_reg[head.source[SRC_W-1:0]] : 16'sd0;

    genvar g;
    generate
        for (g = 0; g < MAX_ROUTINGS; g++)
        begin : g_cell
            mmr_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (sweeping),
                .d     ((g == 0) ? feed : chain[(g == 0) ? 0 : g - 1]),
                .q     (chain[g])
            );
        end
    endgenerate

    mmr_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .clr    (accept),
        .en     (mac_en),
        .level  (head_level),
        .amount (head.amount),
        .acc    (acc)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !immediate)
                begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            id_counter_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                level_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                hit_reg   <= 1'b0;
                if (kind == KIND_SET && src_ok)
                begin
                    level_reg[source_index[SRC_W-1:0]] <= source_value;
                end
            end
            else if (sweeping)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (take_slot)
                begin
                    found_reg <= 1'b1;
                end
                if (drop_slot)
                begin
                    hit_reg <= 1'b1;
                end
            end

            if ((accept && immediate) || (state_reg == S_DONE && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == S_DONE && out_free && kind_reg == KIND_ADD && found_reg)
            begin
                id_counter_reg <= id_counter_reg + 1'b1;
            end
        end
    end

    // operands and transfer payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            src_reg    <= source_index;
            dst_reg    <= dest_index;
            dst_ok_reg <= ({1'b0, dest_index} < DST_LIMIT);
            amt_reg    <= amt_clamped;
            rid_reg    <= routing_id;
        end

        if (accept && immediate)
        begin
            new_id_reg <= '0;
            value_reg  <= (kind == KIND_GET) ? {{21{get_level[15]}}, get_level} : 37'sd0;
            status_reg <= (!src_ok && (kind == KIND_ADD || kind == KIND_SET
                                       || kind == KIND_GET))
                          ? STATUS_BAD_SOURCE : STATUS_OK;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            new_id_reg <= (kind_reg == KIND_ADD && found_reg) ? id_counter_reg : 16'd0;
            value_reg  <= (kind_reg == KIND_QUERY) ? acc : 37'sd0;
            case (kind_reg)
                KIND_ADD:
                begin
                    status_reg <= found_reg ? STATUS_OK : STATUS_FULL;
                end
                KIND_REMOVE:
                begin
                    status_reg <= hit_reg ? STATUS_OK : STATUS_NOT_FOUND;
                end
                default:
                begin
                    status_reg <= STATUS_OK;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign new_id    = new_id_reg;
    assign value     = value_reg;

endmodule

### rtl/core/mmr_cell.sv
`timescale 1ns / 1ps
// mmr_cell: one routing slot of the rotating routing chain
// depends on mmr_pkg for entry_t
module mmr_cell
    import mmr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  entry_t d,
    output entry_t q
);

    logic               valid_reg;
    logic [4:0]         source_reg;
    logic [4:0]         dest_reg;
    logic signed [16:0] amount_reg;
    logic [15:0]        id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            source_reg <= d.source;
            dest_reg   <= d.dest;
            amount_reg <= d.amount;
            id_reg     <= d.id;
        end
    end

    assign q = {valid_reg, source_reg, dest_reg, amount_reg, id_reg};

endmodule

### rtl/core/mmr_mac.sv
`timescale 1ns / 1ps
// mmr_mac: registered multiply then 37-bit wrapping accumulate
// no package dependencies
module mmr_mac
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clr,
    input  logic               en,
    input  logic signed [15:0] level,
    input  logic signed [16:0] amount,
    output logic signed [36:0] acc
);

    logic signed [32:0] prod_reg;
    logic               prod_valid_reg;
    logic signed [36:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else if (clr)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= en;
            if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + {{4{prod_reg[32]}}, prod_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 33'(level) * 33'(amount);
        end
    end

    assign acc = acc_reg;

endmodule

### tb/tb_modulation_matrix_router.sv
`timescale 1ns / 1ps
// tb_modulation_matrix_router: self-checking bench for the modulation matrix router
// depends on mmr_pkg and modulation_matrix_router; holds its own routing table model
// in a small scoreboard class, with random idle on both sides of the handshake
module tb_modulation_matrix_router;
    import mmr_pkg::*;

    localparam int NUM_SLOTS  = 32;
    localparam int NUM_LEVELS = 16;
    localparam int NUM_DESTS  = 32;

    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    typedef struct {
        logic [1:0]         status;
        logic [15:0]        new_id;
        logic signed [36:0] value;
    } outcome_t;

    class router_scoreboard;
        bit                 slot_used [NUM_SLOTS];
        logic [4:0]         slot_src  [NUM_SLOTS];
        logic [4:0]         slot_dst  [NUM_SLOTS];
        logic signed [16:0] slot_depth[NUM_SLOTS];
        logic [15:0]        slot_tag  [NUM_SLOTS];
        logic signed [15:0] level     [NUM_LEVELS];
        logic [15:0]        next_id;
        outcome_t           awaited[$];
        int                 mismatches;
        int                 checked;
        int                 op_count[8];
        int                 full_hits;
        int                 miss_hits;
        int                 bad_hits;
        int                 peak_fill;

        function new();
            int i;
            for (i = 0; i < NUM_SLOTS; i++) slot_used[i] = 1'b0;
            for (i = 0; i < NUM_LEVELS; i++) level[i] = '0;
            for (i = 0; i < 8; i++) op_count[i] = 0;
            next_id    = '0;
            mismatches = 0;
            checked    = 0;
            full_hits  = 0;
            miss_hits  = 0;
            bad_hits   = 0;
            peak_fill  = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // id of a routing that is live now, or any id if the table is empty
        function logic [15:0] live_id();
            logic [15:0] tags[$];
            int i;
            for (i = 0; i < NUM_SLOTS; i++)
                if (slot_used[i]) tags = {tags, slot_tag[i]};
            if (tags.size() == 0) return 16'($urandom);
            return tags[$urandom_range(0, tags.size() - 1)];
        endfunction

        function void note_transfer(logic [2:0] op, logic [4:0] src, logic [4:0] dst,
                                    logic signed [16:0] amt, logic [15:0] rid,
                                    logic signed [15:0] lvl);
            outcome_t res;
            int       slot;
            int       depth;
            int       fill;
            int       i;
            bit       hit;
            longint   acc;
            res.status = STATUS_OK;
            res.new_id = '0;
            res.value  = '0;
            op_count[op]++;
            case (op)
                KIND_ADD:
                begin
                    slot = -1;
                    for (i = NUM_SLOTS - 1; i >= 0; i--)
                        if (!slot_used[i]) slot = i;
                    if (src >= NUM_LEVELS) res.status = STATUS_BAD_SOURCE;
                    else if (slot < 0) res.status = STATUS_FULL;
                    else
                    begin
                        depth = amt;
                        if (depth > 32768) depth = 32768;
                        if (depth < -32768) depth = -32768;
                        slot_used[slot]  = 1'b1;
                        slot_src[slot]   = src;
                        slot_dst[slot]   = dst;
                        slot_depth[slot] = 17'(depth);
                        slot_tag[slot]   = next_id;
                        res.new_id       = next_id;
                        next_id          = next_id + 16'd1;
                    end
                end
                KIND_REMOVE:
                begin
                    hit = 1'b0;
                    for (i = 0; i < NUM_SLOTS; i++)
                        if (slot_used[i] && slot_tag[i] == rid)
                        begin
                            slot_used[i] = 1'b0;
                            hit = 1'b1;
                        end
                    if (!hit) res.status = STATUS_NOT_FOUND;
                end
                KIND_CLEAR:
                begin
                    for (i = 0; i < NUM_SLOTS; i++) slot_used[i] = 1'b0;
                end
                KIND_SET:
                begin
                    if (src < NUM_LEVELS) level[src] = lvl;
                    else res.status = STATUS_BAD_SOURCE;
                end
                KIND_GET:
                begin
                    if (src < NUM_LEVELS) res.value = level[src];
                    else res.status = STATUS_BAD_SOURCE;
                end
                KIND_QUERY:
                begin
                    acc = 0;
                    if (dst < NUM_DESTS)
                        for (i = 0; i < NUM_SLOTS; i++)
                            if (slot_used[i] && slot_dst[i] == dst && slot_src[i] < NUM_LEVELS)
                                acc += longint'(level[slot_src[i]]) * longint'(slot_depth[i]);
                    res.value = acc[36:0];
                end
                default:
                begin
                end
            endcase
            if (res.status == STATUS_FULL) full_hits++;
            if (res.status == STATUS_NOT_FOUND) miss_hits++;
            if (res.status == STATUS_BAD_SOURCE) bad_hits++;
            fill = 0;
            for (i = 0; i < NUM_SLOTS; i++) fill += slot_used[i];
            if (fill > peak_fill) peak_fill = fill;
            awaited = {awaited, res};
        endfunction

        task report(string what, logic [36:0] got, logic [36:0] want);
            $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [1:0] st, logic [15:0] nid, logic signed [36:0] val);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                report("unexpected result", {st, nid, val[18:0]}, '0);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (st !== want.status) report("status", 37'(st), 37'(want.status));
            if (nid !== want.new_id) report("new_id", 37'(nid), 37'(want.new_id));
            if (val !== want.value) report("value", val, want.value);
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         kind = KIND_GET;
    logic [4:0]         source_index = '0;
    logic [4:0]         dest_index = '0;
    logic signed [16:0] amount = '0;
    logic [15:0]        routing_id = '0;
    logic signed [15:0] source_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [15:0]        new_id;
    logic signed [36:0] value;

    bit quiet = 1'b0;

    router_scoreboard sb = new();

    modulation_matrix_router #(
        .MAX_ROUTINGS(NUM_SLOTS),
        .NUM_SOURCES (NUM_LEVELS),
        .NUM_DESTS   (NUM_DESTS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .source_index(source_index),
        .dest_index  (dest_index),
        .amount      (amount),
        .routing_id  (routing_id),
        .source_value(source_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .new_id      (new_id),
        .value       (value)
    );

    always #6 clk = ~clk;

    // mostly short idle, now and then a long one
    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [4:0] src, input logic [4:0] dst,
                             input logic signed [16:0] amt, input logic [15:0] rid,
                             input logic signed [15:0] lvl);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= op;
        source_index <= src;
        dest_index   <= dst;
        amount       <= amt;
        routing_id   <= rid;
        source_value <= lvl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_transfer(op, src, dst, amt, rid, lvl);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // result side: random stall runs, checks every result transfer
    initial
    begin
        int hold;
        bit stalled;
        hold = 0;
        stalled = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) sb.check_result(status, new_id, value);
            if (hold == 0)
            begin
                stalled = !quiet && ($urandom_range(0, 2) == 0);
                hold = stalled ? idle_len() + 1 : $urandom_range(1, 8);
            end
            hold--;
            out_stall <= stalled;
        end
    end

    initial
    begin
        int                 n;
        int                 r;
        int                 burst;
        logic [2:0]         op;
        logic [4:0]         src;
        logic [4:0]         dst;
        logic signed [16:0] amt;
        logic [15:0]        rid;
        logic signed [15:0] lvl;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: level extremes, bad sources, clamping, lowest free slot, queries, remove, spare codes, clear
        send_item(KIND_GET,    5'd0,  5'd0,  17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_SET,    5'd0,  5'd0,  17'h00000, 16'h0000, 16'h8000);
        send_item(KIND_SET,    5'd15, 5'd0,  17'h00000, 16'h0000, 16'h7FFF);
        send_item(KIND_SET,    5'd16, 5'd0,  17'h00000, 16'h0000, 16'h1234);
        send_item(KIND_SET,    5'd31, 5'd31, 17'h1FFFF, 16'hFFFF, 16'hFFFF);
        send_item(KIND_GET,    5'd15, 5'd0,  17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_GET,    5'd31, 5'd0,  17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_ADD,    5'd0,  5'd0,  17'h10000, 16'h0000, 16'h0000);
        send_item(KIND_ADD,    5'd15, 5'd0,  17'h0FFFF, 16'h0000, 16'h0000);
        send_item(KIND_ADD,    5'd15, 5'd31, 17'h17FFF, 16'h0000, 16'h0000);
        send_item(KIND_ADD,    5'd16, 5'd0,  17'h08000, 16'h0000, 16'h0000);
        send_item(KIND_ADD,    5'd0,  5'd1,  17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_QUERY,  5'd0,  5'd0,  17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_QUERY,  5'd0,  5'd31, 17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_QUERY,  5'd0,  5'd2,  17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_REMOVE, 5'd0,  5'd0,  17'h00000, 16'h0001, 16'h0000);
        send_item(KIND_REMOVE, 5'd0,  5'd0,  17'h00000, 16'h0001, 16'h0000);
        send_item(KIND_REMOVE, 5'd0,  5'd0,  17'h00000, 16'hFFFF, 16'h0000);
        send_item(KIND_QUERY,  5'd0,  5'd0,  17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_ADD,    5'd15, 5'd0,  17'h03039, 16'h0000, 16'h0000);
        send_item(KIND_QUERY,  5'd0,  5'd0,  17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_SPARE_A, 5'd31, 5'd31, 17'h1FFFF, 16'hFFFF, 16'hFFFF);
        send_item(KIND_SPARE_B, 5'd5, 5'd7,  17'h0AAAA, 16'h5555, 16'h7FFF);
        send_item(KIND_CLEAR,  5'd0,  5'd0,  17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_QUERY,  5'd0,  5'd0,  17'h00000, 16'h0000, 16'h0000);
        send_item(KIND_REMOVE, 5'd0,  5'd0,  17'h00000, 16'h0002, 16'h0000);
        drain();

        // random: mixed traffic with fill bursts that run the table full
        burst = 0;
        for (n = 0; n < 850; n++)
        begin
            quiet = (n % 200) >= 160;
            if (n % 300 == 150) burst = 36;
            r = $urandom_range(0, 99);
            if (burst > 0) op = KIND_ADD;
            else if (r < 40) op = KIND_ADD;
            else if (r < 53) op = KIND_REMOVE;
            else if (r < 54) op = KIND_CLEAR;
            else if (r < 67) op = KIND_SET;
            else if (r < 77) op = KIND_GET;
            else if (r < 97) op = KIND_QUERY;
            else op = r[0] ? KIND_SPARE_A : KIND_SPARE_B;
            if (burst > 0) burst--;

            src = ($urandom_range(0, 9) == 0 && burst == 0) ? 5'($urandom_range(16, 31))
                                                             : 5'($urandom_range(0, 15));
            dst = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
            if ($urandom_range(0, 4) == 0)
                case ($urandom_range(0, 5))
                    0: amt = 17'h10000;
                    1: amt = 17'h0FFFF;
                    2: amt = 17'h08000;
                    3: amt = 17'h18000;
                    4: amt = 17'h17FFF;
                    default: amt = 17'h00000;
                endcase
            else
                amt = 17'($urandom);
            rid = (op == KIND_REMOVE && $urandom_range(0, 2) != 0) ? sb.live_id()
                                                                   : 16'($urandom);
            if ($urandom_range(0, 7) == 0) lvl = r[1] ? 16'h8000 : 16'h7FFF;
            else lvl = 16'($urandom);

            send_item(op, src, dst, amt, rid, lvl);
            if (n == 425) drain();
        end

        drain();
        repeat (40) @(posedge clk);
        quiet = 1'b1;

        $display("covered %0d results: %0d add, %0d remove, %0d clear, %0d set, %0d get, %0d query",
                 sb.checked, sb.op_count[KIND_ADD], sb.op_count[KIND_REMOVE],
                 sb.op_count[KIND_CLEAR], sb.op_count[KIND_SET], sb.op_count[KIND_GET],
                 sb.op_count[KIND_QUERY]);
        $display("table full %0d times, id misses %0d, bad sources %0d, peak fill %0d of %0d",
                 sb.full_hits, sb.miss_hits, sb.bad_hits, sb.peak_fill, NUM_SLOTS);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule
